### sv/brb_pkg.sv
// Shared types and constants for the byte ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

  localparam int unsigned KIND_W     = 4;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned AMT_W      = 10;
  localparam int unsigned DMA_W      = 11;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned SIZE_MIN   = 2;
  localparam int unsigned SIZE_RESET = 1024;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE   = 4'd0,
    KIND_READ    = 4'd1,
    KIND_PEEK    = 4'd2,
    KIND_BLOCK   = 4'd3,
    KIND_SKIP    = 4'd4,
    KIND_DMA     = 4'd5,
    KIND_RESET   = 4'd6,
    KIND_CLR_OVF = 4'd7,
    KIND_STATUS  = 4'd8
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic cfg_write;
    logic write_byte;
    logic read_tail;
    logic peek_read;
    logic blk_start;
    logic skip;
    logic div_start;
    logic div_step;
    logic dma_nh;
    logic dma_apply;
    logic clear_idx;
    logic clear_ovf;
    logic set_fail;
    logic out_load;
    logic out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              empty;
    logic              peek_fail;
    logic              blk_len_zero;
    logic              blk_last;
    logic              div_done;
    logic              out_ready;
  } sts_t;

endpackage

`default_nettype wire

### sv/brb_datapath.sv
// Datapath of the byte ring buffer: indices, byte store, remainder unit, result register.
`timescale 1ns / 1ps
`default_nettype none

module brb_datapath #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned MAX_BLOCK = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire brb_pkg::cmd_t                cmd_i,
  output brb_pkg::sts_t                     sts_o,
  input  wire logic [brb_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic [brb_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [brb_pkg::DATA_W-1:0]   write_data_i,
  input  wire logic [brb_pkg::AMT_W-1:0]    amount_i,
  input  wire logic [brb_pkg::DMA_W-1:0]    dma_left_i,
  input  wire logic                         out_stall_i,
  output logic                              out_valid_o,
  output logic                              failed_o,
  output logic [brb_pkg::DATA_W-1:0]        read_data_o,
  output logic [brb_pkg::CNT_W-1:0]         moved_count_o,
  output logic [brb_pkg::CNT_W-1:0]         bytes_available_o,
  output logic [brb_pkg::CNT_W-1:0]         bytes_free_o,
  output logic                              is_empty_o,
  output logic                              overflow_seen_o,
  output logic                              last_o
);
  import brb_pkg::*;

  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned SW  = $clog2(DEPTH + 1);
  localparam int unsigned XW  = ((SW > AMT_W) ? SW : AMT_W) + 1;
  localparam int unsigned CXW = (SW > CFG_W) ? SW : CFG_W;
  localparam int unsigned BW  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned DCW = $clog2(DMA_W + 1);
  localparam logic [SW-1:0] RST_SIZE = SW'((DEPTH < SIZE_RESET) ? DEPTH : SIZE_RESET);

  logic [SW-1:0]     size_q;
  logic [IW-1:0]     head_q, tail_q;
  logic              ovf_q;
  logic [KIND_W-1:0] kind_q;
  logic [DATA_W-1:0] wdata_q;
  logic [AMT_W-1:0]  amount_q;
  logic [DMA_W-1:0]  dividend_q;
  logic [IW-1:0]     avail_q;
  logic [AMT_W-1:0]  moved_q;
  logic [BW-1:0]     len_q;
  logic              fail_q, sel_mem_q;
  logic [DATA_W-1:0] rdata_q;
  logic [SW-1:0]     acc_q;
  logic [DCW-1:0]    div_cnt_q;
  logic [IW-1:0]     nh_q;
  logic [DATA_W-1:0] mem [DEPTH];

  logic              out_valid_q, failed_q, empty_q, ovf_out_q, last_q;
  logic [DATA_W-1:0] read_data_q;
  logic [CNT_W-1:0]  moved_out_q, avail_out_q, free_out_q;

  logic [IW-1:0] avail_c;
  logic [SW-1:0] free_c;
  logic [SW-1:0] head_p1, tail_p1, nh_p1;
  logic [IW-1:0] head_nxt, tail_nxt, nh_nxt;
  logic [XW-1:0] peek_sum, blk_cap, blk_len, skip_len, skip_sum;
  logic [IW-1:0] peek_addr, skip_tail, rd_addr;
  logic [SW:0]   div_part;
  logic          div_ge;
  logic [SW-1:0] acc_d;
  logic [SW-1:0] written, freesp;
  logic          overrun;
  logic [CXW-1:0] cfg_ext;
  logic [SW-1:0] cfg_size;
  logic          out_ready;

  // Occupancy from the live indices.
  always_comb begin
    if (head_q >= tail_q) begin
      avail_c = IW'(SW'(head_q) - SW'(tail_q));
    end else begin
      avail_c = IW'(size_q - SW'(tail_q) + SW'(head_q));
    end
    free_c = size_q - SW'(avail_c) - SW'(1);
  end

  // Index increments with wrap at the size in use.
  always_comb begin
    head_p1  = SW'(head_q) + SW'(1);
    tail_p1  = SW'(tail_q) + SW'(1);
    nh_p1    = SW'(nh_q) + SW'(1);
    head_nxt = (head_p1 == size_q) ? '0 : IW'(head_p1);
    tail_nxt = (tail_p1 == size_q) ? '0 : IW'(tail_p1);
    nh_nxt   = (nh_p1 == size_q) ? '0 : IW'(nh_p1);
  end

  // Peek, block and skip use the occupancy registered at dispatch.
  always_comb begin
    peek_sum  = XW'(tail_q) + XW'(amount_q);
    peek_addr = (peek_sum >= XW'(size_q)) ? IW'(peek_sum - XW'(size_q)) : IW'(peek_sum);
    blk_cap   = (XW'(amount_q) > XW'(MAX_BLOCK)) ? XW'(MAX_BLOCK) : XW'(amount_q);
    blk_len   = (blk_cap > XW'(avail_q)) ? XW'(avail_q) : blk_cap;
    skip_len  = (XW'(amount_q) > XW'(avail_q)) ? XW'(avail_q) : XW'(amount_q);
    skip_sum  = XW'(tail_q) + skip_len;
    skip_tail = (skip_sum >= XW'(size_q)) ? IW'(skip_sum - XW'(size_q)) : IW'(skip_sum);
    rd_addr   = cmd_i.peek_read ? peek_addr : tail_q;
  end

  // One bit of the remainder per step, dividend MSB first.
  always_comb begin
    div_part = {acc_q, dividend_q[DMA_W-1]};
    div_ge   = div_part >= {1'b0, size_q};
    acc_d    = div_ge ? SW'(div_part - {1'b0, size_q}) : SW'(div_part);
  end

  // Bytes the DMA moved the head by, against the free space.
  always_comb begin
    if (nh_q >= head_q) begin
      written = SW'(nh_q) - SW'(head_q);
    end else begin
      written = size_q - SW'(head_q) + SW'(nh_q);
    end
    freesp  = size_q - SW'(avail_q) - SW'(1);
    overrun = written > freesp;
  end

  always_comb begin
    cfg_ext = CXW'(cfg_data_i);
    if (cfg_ext < CXW'(SIZE_MIN)) begin
      cfg_size = SW'(SIZE_MIN);
    end else if (cfg_ext > CXW'(DEPTH)) begin
      cfg_size = SW'(DEPTH);
    end else begin
      cfg_size = SW'(cfg_ext);
    end
  end

  assign out_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o              = '0;
    sts_o.kind         = kind_q;
    sts_o.full         = (head_nxt == tail_q);
    sts_o.empty        = (head_q == tail_q);
    sts_o.peek_fail    = (XW'(amount_q) >= XW'(avail_q));
    sts_o.blk_len_zero = (blk_len == '0);
    sts_o.blk_last     = (moved_q == AMT_W'(len_q));
    sts_o.div_done     = (div_cnt_q == '0);
    sts_o.out_ready    = out_ready;
  end

  // Ring state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= RST_SIZE;
      head_q    <= '0;
      tail_q    <= '0;
      ovf_q     <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      if (cmd_i.cfg_write) begin
        size_q <= cfg_size;
        head_q <= '0;
        tail_q <= '0;
        ovf_q  <= 1'b0;
      end else begin
        if (cmd_i.clear_idx) begin
          head_q <= '0;
          tail_q <= '0;
          ovf_q  <= 1'b0;
        end
        if (cmd_i.write_byte) begin
          head_q <= head_nxt;
        end
        if (cmd_i.read_tail) begin
          tail_q <= tail_nxt;
        end
        if (cmd_i.skip) begin
          tail_q <= skip_tail;
        end
        if (cmd_i.dma_apply) begin
          head_q <= nh_q;
          if (overrun) begin
            ovf_q  <= 1'b1;
            tail_q <= nh_nxt;
          end
        end
        if (cmd_i.clear_ovf) begin
          ovf_q <= 1'b0;
        end
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= DCW'(DMA_W);
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q - DCW'(1);
      end
    end
  end

  // Item fields and per-item working registers.
  always_ff @(posedge clk_i) begin
    avail_q <= avail_c;
    if (cmd_i.capture) begin
      kind_q     <= kind_i;
      wdata_q    <= write_data_i;
      amount_q   <= amount_i;
      dividend_q <= dma_left_i;
      moved_q    <= '0;
      fail_q     <= 1'b0;
      sel_mem_q  <= 1'b0;
    end else begin
      if (cmd_i.set_fail) begin
        fail_q <= 1'b1;
      end
      if (cmd_i.read_tail) begin
        moved_q <= moved_q + AMT_W'(1);
      end
      if (cmd_i.skip) begin
        moved_q <= AMT_W'(skip_len);
      end
      if (cmd_i.read_tail || cmd_i.peek_read) begin
        sel_mem_q <= 1'b1;
      end
      if (cmd_i.div_step) begin
        dividend_q <= {dividend_q[DMA_W-2:0], 1'b0};
      end
    end
    if (cmd_i.blk_start) begin
      len_q <= BW'(blk_len);
    end
    if (cmd_i.div_start) begin
      acc_q <= '0;
    end else if (cmd_i.div_step) begin
      acc_q <= acc_d;
    end
    if (cmd_i.dma_nh) begin
      nh_q <= (acc_q == '0) ? '0 : IW'(size_q - acc_q);
    end
  end

  // Byte store, one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_byte) begin
      mem[head_q] <= wdata_q;
    end
    if (cmd_i.read_tail || cmd_i.peek_read) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      failed_q    <= fail_q;
      read_data_q <= sel_mem_q ? rdata_q : '0;
      moved_out_q <= CNT_W'(moved_q);
      avail_out_q <= CNT_W'(avail_c);
      free_out_q  <= CNT_W'(free_c);
      empty_q     <= (head_q == tail_q);
      ovf_out_q   <= ovf_q;
      last_q      <= cmd_i.out_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign failed_o          = failed_q;
  assign read_data_o       = read_data_q;
  assign moved_count_o     = moved_out_q;
  assign bytes_available_o = avail_out_q;
  assign bytes_free_o      = free_out_q;
  assign is_empty_o        = empty_q;
  assign overflow_seen_o   = ovf_out_q;
  assign last_o            = last_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(head_q) < size_q) && (SW'(tail_q) < size_q))
    else $error("ring index outside size in use");

  a_size_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_q >= SW'(SIZE_MIN)) && (SW'(size_q) <= SW'(DEPTH)))
    else $error("size in use out of range");

  a_load_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_ready)
    else $error("result overwritten before it was taken");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_byte |-> (head_nxt != tail_q))
    else $error("byte stored into a full ring");

endmodule

`default_nettype wire

### sv/brb_ctrl.sv
// Controller state machine of the byte ring buffer.
`timescale 1ns / 1ps
`default_nettype none

module brb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire brb_pkg::sts_t sts_i,
  output brb_pkg::cmd_t      cmd_o
);
  import brb_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_DISPATCH  = 8'b0000_0010,
    ST_EMIT      = 8'b0000_0100,
    ST_BLK_OUT   = 8'b0000_1000,
    ST_DIV       = 8'b0001_0000,
    ST_DMA_NH    = 8'b0010_0000,
    ST_DMA_APPLY = 8'b0100_0000,
    ST_SPARE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.cfg_write = cfg_valid_i;
        if (in_valid_i && !cfg_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_EMIT;
        case (sts_i.kind)
          KIND_WRITE: begin
            if (sts_i.full) cmd_o.set_fail = 1'b1;
            else            cmd_o.write_byte = 1'b1;
          end
          KIND_READ: begin
            if (sts_i.empty) cmd_o.set_fail = 1'b1;
            else             cmd_o.read_tail = 1'b1;
          end
          KIND_PEEK: begin
            if (sts_i.peek_fail) cmd_o.set_fail = 1'b1;
            else                 cmd_o.peek_read = 1'b1;
          end
          KIND_BLOCK: begin
            if (!sts_i.blk_len_zero) begin
              cmd_o.blk_start = 1'b1;
              cmd_o.read_tail = 1'b1;
              state_d         = ST_BLK_OUT;
            end
          end
          KIND_SKIP: begin
            cmd_o.skip = 1'b1;
          end
          KIND_DMA: begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
          KIND_RESET: begin
            cmd_o.clear_idx = 1'b1;
          end
          KIND_CLR_OVF: begin
            cmd_o.clear_ovf = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_EMIT: begin
        if (sts_i.out_ready) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_BLK_OUT: begin
        if (sts_i.out_ready) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = sts_i.blk_last;
          if (sts_i.blk_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.read_tail = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_DMA_NH;
        else                cmd_o.div_step = 1'b1;
      end
      ST_DMA_NH: begin
        cmd_o.dma_nh = 1'b1;
        state_d      = ST_DMA_APPLY;
      end
      ST_DMA_APPLY: begin
        cmd_o.dma_apply = 1'b1;
        state_d         = ST_EMIT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

  a_blk_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLK_OUT && cmd_o.out_load && !sts_i.blk_last) |=> state_q == ST_BLK_OUT)
    else $error("block read ended before its last byte");

  a_blk_no_overread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLK_OUT && cmd_o.read_tail) |-> !sts_i.blk_last)
    else $error("block read fetched past its length");

endmodule

`default_nettype wire

### sv/byte_ring_buffer_dma_overflow.sv
// Top level of the byte ring buffer with DMA head update and sticky overflow.
`timescale 1ns / 1ps
`default_nettype none

// Byte ring buffer that keeps one slot empty, so it holds at most size-1 bytes. The size in
// use is written on the configuration channel (clamped to 2..DEPTH, reset value 1024 or DEPTH
// if smaller); a write also clears head, tail and the overflow flag. Each input item carries one
// operation: write, read byte, peek, block read (one result per byte, up to MAX_BLOCK, last set
// on the final one), skip, DMA head update, index reset, overflow clear or status. Items are
// taken one at a time by the controller. Write, read, peek, skip, reset, clear and status pass
// through the dispatch and emit states; a block read gives one byte per cycle from the store's
// single read port while the output is not stalled; a DMA update runs the bit-serial remainder
// unit that reduces the remaining count modulo the size, one dividend bit per cycle. A finished
// result sits in the output register while the next item is accepted. Bytes never written to
// the store read as undefined. Input is stalled while a configuration write is offered.
module byte_ring_buffer_dma_overflow #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned MAX_BLOCK = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration channel
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [brb_pkg::CFG_W-1:0]    cfg_data_i,
  // input item channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [brb_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [brb_pkg::DATA_W-1:0]   write_data_i,
  input  wire logic [brb_pkg::AMT_W-1:0]    amount_i,
  input  wire logic [brb_pkg::DMA_W-1:0]    dma_left_i,
  // result item channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              failed_o,
  output logic [brb_pkg::DATA_W-1:0]        read_data_o,
  output logic [brb_pkg::CNT_W-1:0]         moved_count_o,
  output logic [brb_pkg::CNT_W-1:0]         bytes_available_o,
  output logic [brb_pkg::CNT_W-1:0]         bytes_free_o,
  output logic                              is_empty_o,
  output logic                              overflow_seen_o,
  output logic                              last_o
);
  import brb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: sequence each item and hold off input until its results are loaded.
  brb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: indices, byte store, remainder unit and the result register.
  brb_datapath #(
    .DEPTH     (DEPTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_data_i        (cfg_data_i),
    .kind_i            (kind_i),
    .write_data_i      (write_data_i),
    .amount_i          (amount_i),
    .dma_left_i        (dma_left_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .failed_o          (failed_o),
    .read_data_o       (read_data_o),
    .moved_count_o     (moved_count_o),
    .bytes_available_o (bytes_available_o),
    .bytes_free_o      (bytes_free_o),
    .is_empty_o        (is_empty_o),
    .overflow_seen_o   (overflow_seen_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

### tb/byte_ring_buffer_dma_overflow_test.sv
// Self-checking testbench for the byte ring buffer with DMA head update and overflow flag.
`timescale 1ns / 1ps

// Each item on the input channel is checked against a cycle-free predictor of the ring buffer.
// The predictor keeps two views of the buffer state. The stimulus view is stepped while items
// are queued, so the generator knows head, tail and which store bytes hold data. That lets it
// steer reads, peeks and block reads away from store entries that were never written. The
// device view is stepped when the block takes an item, and it fills the queue of expected
// results. The run has a directed opening at the reset size and then several phases. Each
// phase writes a new buffer size, the extremes among them, and then sends random items.
module byte_ring_buffer_dma_overflow_test;
  import brb_pkg::*;

  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned MAX_BLOCK = 64;

  // Views of the predicted buffer state.
  localparam int STIM_VIEW = 0;
  localparam int DUT_VIEW  = 1;

  // Kinds beyond the defined ones behave as status.
  localparam logic [KIND_W-1:0] KIND_UNDEF_MIN = 4'd9;
  localparam logic [KIND_W-1:0] KIND_UNDEF_MAX = 4'd15;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 56;
  localparam int DRAIN_CYCLES    = 80;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] write_data;
    logic [AMT_W-1:0]  amount;
    logic [DMA_W-1:0]  dma_left;
  } ring_op_t;

  typedef struct packed {
    logic              failed;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  moved_count;
    logic [CNT_W-1:0]  bytes_available;
    logic [CNT_W-1:0]  bytes_free;
    logic              is_empty;
    logic              overflow_seen;
    logic              last;
  } ring_result_t;

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                cfg_valid_i       = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_data_i        = '0;
  logic                in_valid_i        = 1'b0;
  logic                in_stall_o;
  logic [KIND_W-1:0]   kind_i            = '0;
  logic [DATA_W-1:0]   write_data_i      = '0;
  logic [AMT_W-1:0]    amount_i          = '0;
  logic [DMA_W-1:0]    dma_left_i        = '0;
  logic                out_valid_o;
  logic                out_stall_i       = 1'b0;
  logic                failed_o;
  logic [DATA_W-1:0]   read_data_o;
  logic [CNT_W-1:0]    moved_count_o;
  logic [CNT_W-1:0]    bytes_available_o;
  logic [CNT_W-1:0]    bytes_free_o;
  logic                is_empty_o;
  logic                overflow_seen_o;
  logic                last_o;

  // Predicted buffer state, one copy per view.
  logic [DATA_W-1:0]   ring_bytes   [2][DEPTH];
  bit                  ring_written [2][DEPTH];
  int unsigned         ring_head    [2];
  int unsigned         ring_tail    [2];
  int unsigned         ring_size    [2];
  bit                  ring_ovf     [2];

  ring_result_t        step_results[$];
  ring_result_t        expected_results[$];
  ring_op_t            pending_ops[$];
  ring_op_t            cur_op;

  bit                  item_taken;
  int                  burst_left = 1;
  int                  gap_left;
  bit                  stall_busy;
  int                  stall_phase_left;
  int                  stall_run;

  int                  mismatch_count;
  int                  items_taken;
  int                  results_checked;
  int                  failed_results;
  int                  overflow_results;
  int                  sizes_used;

  byte_ring_buffer_dma_overflow #(
    .DEPTH     (DEPTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .write_data_i      (write_data_i),
    .amount_i          (amount_i),
    .dma_left_i        (dma_left_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .failed_o          (failed_o),
    .read_data_o       (read_data_o),
    .moved_count_o     (moved_count_o),
    .bytes_available_o (bytes_available_o),
    .bytes_free_o      (bytes_free_o),
    .is_empty_o        (is_empty_o),
    .overflow_seen_o   (overflow_seen_o),
    .last_o            (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------------
  // Ring buffer predictor
  // ---------------------------------------------------------------------------------------------

  function automatic int unsigned ring_avail(input int m);
    if (ring_head[m] >= ring_tail[m]) return ring_head[m] - ring_tail[m];
    return ring_size[m] - ring_tail[m] + ring_head[m];
  endfunction

  // Append one result that reports the counts as they stand now.
  function automatic void ring_emit(input int m, input bit failed, input int unsigned data,
                                    input int unsigned moved, input bit last);
    ring_result_t res;
    int unsigned  a;
    a = ring_avail(m);
    res.failed          = failed;
    res.read_data       = DATA_W'(data);
    res.moved_count     = CNT_W'(moved);
    res.bytes_available = CNT_W'(a);
    res.bytes_free      = CNT_W'(ring_size[m] - a - 1);
    res.is_empty        = (ring_head[m] == ring_tail[m]);
    res.overflow_seen   = ring_ovf[m];
    res.last            = last;
    step_results.push_back(res);
  endfunction

  // A size write clamps to the legal range and clears the indices and the flag.
  function automatic void ring_configure(input int m, input logic [CFG_W-1:0] value);
    int unsigned v;
    v = value;
    if (v < SIZE_MIN) v = SIZE_MIN;
    if (v > DEPTH) v = DEPTH;
    ring_size[m] = v;
    ring_head[m] = 0;
    ring_tail[m] = 0;
    ring_ovf[m]  = 1'b0;
  endfunction

  // Apply one item to a view and leave its results in step_results.
  function automatic void ring_step(input int m, input ring_op_t op);
    int unsigned s, a, len, r, nh, span;
    s = ring_size[m];
    a = ring_avail(m);
    step_results.delete();
    case (op.kind)
      KIND_WRITE: begin
        if ((ring_head[m] + 1) % s == ring_tail[m]) begin
          ring_emit(m, 1'b1, 0, 0, 1'b1);
        end else begin
          ring_bytes[m][ring_head[m]]   = op.write_data;
          ring_written[m][ring_head[m]] = 1'b1;
          ring_head[m] = (ring_head[m] + 1) % s;
          ring_emit(m, 1'b0, 0, 0, 1'b1);
        end
      end
      KIND_READ: begin
        if (a == 0) begin
          ring_emit(m, 1'b1, 0, 0, 1'b1);
        end else begin
          r = ring_bytes[m][ring_tail[m]];
          ring_tail[m] = (ring_tail[m] + 1) % s;
          ring_emit(m, 1'b0, r, 1, 1'b1);
        end
      end
      KIND_PEEK: begin
        if (op.amount >= a) ring_emit(m, 1'b1, 0, 0, 1'b1);
        else ring_emit(m, 1'b0, ring_bytes[m][(ring_tail[m] + op.amount) % s], 0, 1'b1);
      end
      KIND_BLOCK: begin
        len = op.amount;
        if (len > MAX_BLOCK) len = MAX_BLOCK;
        if (len > a) len = a;
        if (len == 0) ring_emit(m, 1'b0, 0, 0, 1'b1);
        for (int unsigned k = 0; k < len; k++) begin
          r = ring_bytes[m][ring_tail[m]];
          ring_tail[m] = (ring_tail[m] + 1) % s;
          ring_emit(m, 1'b0, r, k + 1, k + 1 == len);
        end
      end
      KIND_SKIP: begin
        len = (op.amount > a) ? a : op.amount;
        ring_tail[m] = (ring_tail[m] + len) % s;
        ring_emit(m, 1'b0, 0, len, 1'b1);
      end
      KIND_DMA: begin
        r    = op.dma_left % s;
        nh   = (r == 0) ? 0 : s - r;
        span = (nh >= ring_head[m]) ? nh - ring_head[m] : s - ring_head[m] + nh;
        // The DMA overran unread data: flag it and push the tail past the new head.
        if (span > s - a - 1) begin
          ring_ovf[m]  = 1'b1;
          ring_tail[m] = (nh + 1) % s;
        end
        ring_head[m] = nh;
        ring_emit(m, 1'b0, 0, 0, 1'b1);
      end
      KIND_RESET: begin
        ring_head[m] = 0;
        ring_tail[m] = 0;
        ring_ovf[m]  = 1'b0;
        ring_emit(m, 1'b0, 0, 0, 1'b1);
      end
      KIND_CLR_OVF: begin
        ring_ovf[m] = 1'b0;
        ring_emit(m, 1'b0, 0, 0, 1'b1);
      end
      default: ring_emit(m, 1'b0, 0, 0, 1'b1);
    endcase
  endfunction

  // Queue one item. Steer any access to a store entry that never got a byte: a read becomes a
  // one-byte skip, a peek moves to the first failing offset, a block read stops short.
  function automatic void queue_item(input logic [KIND_W-1:0] kind,
                                     input logic [DATA_W-1:0] data,
                                     input logic [AMT_W-1:0] amt,
                                     input logic [DMA_W-1:0] rem);
    ring_op_t    op;
    int unsigned s, a, t, len, k;
    s = ring_size[STIM_VIEW];
    a = ring_avail(STIM_VIEW);
    t = ring_tail[STIM_VIEW];
    op.kind       = kind;
    op.write_data = data;
    op.amount     = amt;
    op.dma_left   = rem;
    case (kind)
      KIND_READ: begin
        if (a != 0 && !ring_written[STIM_VIEW][t]) begin
          op.kind   = KIND_SKIP;
          op.amount = 1;
        end
      end
      KIND_PEEK: begin
        if (amt < a && !ring_written[STIM_VIEW][(t + amt) % s]) op.amount = AMT_W'(a);
      end
      KIND_BLOCK: begin
        len = amt;
        if (len > MAX_BLOCK) len = MAX_BLOCK;
        if (len > a) len = a;
        k = 0;
        while (k < len && ring_written[STIM_VIEW][(t + k) % s]) k++;
        if (k < len) op.amount = AMT_W'(k);
      end
      default: ;
    endcase
    ring_step(STIM_VIEW, op);
    pending_ops.push_back(op);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Hold until every queued item has gone in and every expected result has come out.
  task automatic wait_idle();
    while (pending_ops.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------------------------
  // Driver: present items from the queue in bursts with random gaps between them.
  // ---------------------------------------------------------------------------------------------
  always @(negedge clk_i) begin : item_driver
    bit next_valid;
    next_valid = in_valid_i;
    // Drop the item that went in at the last rising edge.
    if (item_taken) next_valid = 1'b0;
    if (rst_ni && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() != 0) begin
        cur_op       = pending_ops.pop_front();
        next_valid   = 1'b1;
        kind_i       <= cur_op.kind;
        write_data_i <= cur_op.write_data;
        amount_i     <= cur_op.amount;
        dma_left_i   <= cur_op.dma_left;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20)
                                                   : $urandom_range(1, 4);
        end
      end
    end
    in_valid_i <= next_valid;
  end

  // ---------------------------------------------------------------------------------------------
  // Receiver: alternate quiet stretches with busy ones that stall in short runs.
  // ---------------------------------------------------------------------------------------------
  always @(negedge clk_i) begin : result_stall
    if (stall_phase_left == 0) begin
      stall_busy       = !stall_busy;
      stall_phase_left = $urandom_range(10, 60);
    end
    stall_phase_left--;
    if (stall_run > 0) stall_run--;
    else if (stall_busy && $urandom_range(0, 2) == 0) stall_run = $urandom_range(1, 4);
    out_stall_i <= (stall_run > 0);
  end

  // ---------------------------------------------------------------------------------------------
  // Monitor: check each result, then predict the results of a newly taken item.
  // ---------------------------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    ring_result_t got, want;
    item_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.failed          = failed_o;
        got.read_data       = read_data_o;
        got.moved_count     = moved_count_o;
        got.bytes_available = bytes_available_o;
        got.bytes_free      = bytes_free_o;
        got.is_empty        = is_empty_o;
        got.overflow_seen   = overflow_seen_o;
        got.last            = last_o;
        results_checked++;
        if (got.failed) failed_results++;
        if (got.overflow_seen) overflow_results++;
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with none expected, actual %h", $time, got);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("failed", want.failed, got.failed);
          check_field("read_data", want.read_data, got.read_data);
          check_field("moved_count", want.moved_count, got.moved_count);
          check_field("bytes_available", want.bytes_available, got.bytes_available);
          check_field("bytes_free", want.bytes_free, got.bytes_free);
          check_field("is_empty", want.is_empty, got.is_empty);
          check_field("overflow_seen", want.overflow_seen, got.overflow_seen);
          check_field("last", want.last, got.last);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        ring_step(DUT_VIEW, cur_op);
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
        item_taken = 1'b1;
        items_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_W-1:0]  size_writes [PHASES];
    logic [KIND_W-1:0] kind;
    logic [AMT_W-1:0]  amt;
    logic [DMA_W-1:0]  rem;
    int unsigned       s, a, pick;

    for (int m = 0; m < 2; m++) ring_size[m] = SIZE_RESET;
    // Below the minimum, the maximum, odd small sizes and all bits set.
    size_writes = '{11'd0, 11'd3, 11'd2047, 11'd1, 11'd17, 11'd1024,
                    CFG_W'($urandom_range(4, 300)), 11'd2};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    sizes_used = 1;

    // Directed opening at the reset size with an empty, never-written store.
    queue_item(KIND_STATUS, 8'h00, 10'd0, 11'd0);
    queue_item(KIND_READ, 8'h00, 10'd0, 11'd0);     // read when empty fails
    queue_item(KIND_PEEK, 8'h00, 10'd0, 11'd0);     // peek when empty fails
    queue_item(KIND_BLOCK, 8'h00, 10'd5, 11'd0);    // zero-length block read
    queue_item(KIND_SKIP, 8'h00, 10'h3FF, 11'd0);   // skip saturates at nothing
    queue_item(KIND_WRITE, 8'h00, 10'd0, 11'd0);
    queue_item(KIND_WRITE, 8'hFF, 10'd0, 11'd0);
    queue_item(KIND_WRITE, 8'hA5, 10'd0, 11'd0);
    queue_item(KIND_WRITE, 8'h5A, 10'd0, 11'd0);
    queue_item(KIND_PEEK, 8'h00, 10'd0, 11'd0);
    queue_item(KIND_PEEK, 8'h00, 10'd3, 11'd0);
    queue_item(KIND_PEEK, 8'h00, 10'h3FF, 11'd0);   // offset past the data fails
    queue_item(KIND_READ, 8'h00, 10'd0, 11'd0);
    queue_item(KIND_BLOCK, 8'h00, 10'h3FF, 11'd0);  // length capped by the data
    queue_item(KIND_WRITE, 8'h3C, 10'd0, 11'd0);
    queue_item(KIND_DMA, 8'h00, 10'd0, 11'h7FF);    // remaining above the size wraps
    queue_item(KIND_DMA, 8'h00, 10'd0, 11'd1000);   // overruns unread data
    queue_item(KIND_WRITE, 8'h11, 10'd0, 11'd0);    // write when full fails
    queue_item(KIND_STATUS, 8'h00, 10'd0, 11'd0);
    queue_item(KIND_CLR_OVF, 8'h00, 10'd0, 11'd0);
    queue_item(KIND_DMA, 8'h00, 10'd0, 11'd0);      // head to zero, overrun again
    queue_item(KIND_RESET, 8'h00, 10'd0, 11'd0);
    queue_item(KIND_UNDEF_MAX, 8'hFF, 10'h3FF, 11'h7FF);
    queue_item(KIND_WRITE, 8'h81, 10'd0, 11'd0);
    queue_item(KIND_SKIP, 8'h00, 10'h3FF, 11'd0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      // Write the size while the block is idle.
      cfg_valid_i <= 1'b1;
      cfg_data_i  <= size_writes[p];
      do @(posedge clk_i); while (!cfg_ready_o);
      ring_configure(DUT_VIEW, size_writes[p]);
      ring_configure(STIM_VIEW, size_writes[p]);
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;
      sizes_used++;

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        s    = ring_size[STIM_VIEW];
        a    = ring_avail(STIM_VIEW);
        pick = $urandom_range(0, 99);
        if (pick < 36)      kind = KIND_WRITE;
        else if (pick < 50) kind = KIND_READ;
        else if (pick < 58) kind = KIND_PEEK;
        else if (pick < 68) kind = KIND_BLOCK;
        else if (pick < 74) kind = KIND_SKIP;
        else if (pick < 84) kind = KIND_DMA;
        else if (pick < 86) kind = KIND_RESET;
        else if (pick < 90) kind = KIND_CLR_OVF;
        else if (pick < 95) kind = KIND_STATUS;
        else kind = KIND_W'($urandom_range(KIND_UNDEF_MIN, KIND_UNDEF_MAX));

        // Mostly offsets and lengths near the stored count, sometimes any value.
        if ($urandom_range(0, 4) == 0) amt = AMT_W'($urandom);
        else amt = AMT_W'($urandom_range(0, (a + 1 > 1023) ? 1023 : a + 1));

        // Often a DMA advance that fits the free space, else a remaining count up to the size or any value.
        pick = $urandom_range(0, 19);
        if (pick < 4)       rem = DMA_W'($urandom);
        else if (pick < 13) rem = DMA_W'(s - (ring_head[STIM_VIEW] +
                                              $urandom_range(0, s - a - 1)) % s);
        else                rem = DMA_W'($urandom_range(0, s));

        queue_item(kind, DATA_W'($urandom), amt, rem);
      end
      wait_idle();
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Ran %0d items over %0d buffer sizes, checked %0d results.",
             items_taken, sizes_used, results_checked);
    $display("Refused operations: %0d results, overflow flag up: %0d results.",
             failed_results, overflow_results);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timeout with %0d results still expected", expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
sv/brb_pkg.sv
sv/brb_datapath.sv
sv/brb_ctrl.sv
sv/byte_ring_buffer_dma_overflow.sv
tb/byte_ring_buffer_dma_overflow_test.sv
